@@ rtl/core/mfb_pkg.sv @@
// Shared types and constants for the monochrome frame store with rotation.
// No dependencies.
`timescale 1ns / 1ps

package mfb_pkg;

	localparam int DEF_PANEL_WIDTH  = 160;
	localparam int DEF_PANEL_HEIGHT = 160;

	localparam int COORD_W   = 10;
	localparam int PAD_EVERY = 20;
	localparam int PAD_CNT_W = 5;

	typedef enum logic [1:0] {
		OP_DRAW        = 2'd0,
		OP_FLUSH_BEGIN = 2'd1,
		OP_FLUSH_STEP  = 2'd2
	} mfb_op_t;

	localparam logic [1:0] CFG_ROTATION = 2'd0;
	localparam logic [1:0] CFG_MIRROR_X = 2'd1;
	localparam logic [1:0] CFG_MIRROR_Y = 2'd2;

	localparam logic [7:0] FLUSH_CMDS [4] = '{8'h60, 8'h70, 8'h12, 8'h05};
	localparam logic [7:0] PAD_BYTE = 8'h00;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} mfb_alu_op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAPC,
		ST_MAPR,
		ST_ADDR,
		ST_RD,
		ST_WR,
		ST_CMD,
		ST_FRD,
		ST_DATA,
		ST_PAD
	} mfb_state_t;

endpackage

@@ rtl/core/mfb_alu.sv @@
// Shared add/subtract unit used by the sequencer for the store index and coordinate steps.
// Depends on mfb_pkg.
`timescale 1ns / 1ps

module mfb_alu #(
	parameter int W = 12
) (
	input  mfb_pkg::mfb_alu_op_t op,
	input  logic signed [W-1:0]  a,
	input  logic signed [W-1:0]  b,
	output logic signed [W-1:0]  y
);
	import mfb_pkg::*;

	always_comb begin
		case (op)
			ALU_SUB: y = a - b;
			default: y = a + b;
		endcase
	end

endmodule

@@ rtl/core/mfb_store.sv @@
// Frame store memory: one write port, one read port with registered data.
// No package dependencies.
`timescale 1ns / 1ps

module mfb_store #(
	parameter int DEPTH  = 3200,
	parameter int ADDR_W = 12
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata_q
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/mono_framebuffer_rotate_flush_core.sv @@
// Monochrome frame store with rotation and a nibble-expanding flush (top level).
// Depends on mfb_pkg, mfb_alu, mfb_store.
`timescale 1ns / 1ps

// One bit per pixel, column-major: pixel (col,row) is byte col*STRIDE + row/8,
// bit row%8, STRIDE = ceil(PANEL_HEIGHT/8). After reset the block sweeps the
// store to zero, one byte per cycle (PANEL_WIDTH*STRIDE bytes, 3200 at the
// default 160x160); s_tready stays low meanwhile, APB writes are taken. Input
// items are taken one at a time; s_tready is high only between items. Steps of
// each item, set by the single shared adder, the read-modify-write of the store
// and the byte-wide output register:
//   draw        : map column, map row, address, read, write back; it ends
//                 after the address step when the mapped point is off panel
//   flush begin : four command bytes
//   flush step  : store read, four data bytes, and a pad byte when one is due
// Output backpressure holds the sequencer while a byte waits on m_tready.
// The final byte of an item sits in the output register while the next item
// is already accepted.
// Draws map (pos_x,pos_y) through rotation and mirror bits captured at transfer;
// off-panel points are dropped. A flush step reads downward from the last byte,
// wrapping from byte 0 back to the last byte, and inserts a zero pad data byte
// after every 20th byte read since the last pad or flush begin.

module mono_framebuffer_rotate_flush_core #(
	parameter int PANEL_WIDTH  = mfb_pkg::DEF_PANEL_WIDTH,
	parameter int PANEL_HEIGHT = mfb_pkg::DEF_PANEL_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // pos_x[9:0], pos_y[19:10], ink_white[20], zero[23:21]
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte[7:0]
	output logic        m_tuser,   // is_command[0]
	output logic        m_tlast,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mfb_pkg::*;

	localparam int STRIDE   = (PANEL_HEIGHT + 7) / 8;
	localparam int FS_BYTES = PANEL_WIDTH * STRIDE;
	localparam int ADDR_W   = $clog2(FS_BYTES);
	localparam int ALU_W    = (ADDR_W + 1 > 12) ? ADDR_W + 1 : 12;
	localparam int CW       = $clog2(PANEL_WIDTH);
	localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(FS_BYTES - 1);

	// ---------------- configuration registers ----------------
	logic [1:0] rotation_q;
	logic       mirror_x_q;
	logic       mirror_y_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q <= 2'd0;
			mirror_x_q <= 1'b0;
			mirror_y_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				CFG_ROTATION: rotation_q <= pwdata[1:0];
				CFG_MIRROR_X: mirror_x_q <= pwdata[0];
				CFG_MIRROR_Y: mirror_y_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			CFG_ROTATION: prdata = {30'd0, rotation_q};
			CFG_MIRROR_X: prdata = {31'd0, mirror_x_q};
			CFG_MIRROR_Y: prdata = {31'd0, mirror_y_q};
			default:      prdata = 32'd0;
		endcase
	end

	// ---------------- input decode ----------------
	logic [COORD_W-1:0] in_x;
	logic [COORD_W-1:0] in_y;
	logic               in_ink;
	mfb_op_t            in_op;
	logic               in_xfer;
	logic               swap_xy;
	logic               rev_a;
	logic               rev_b;

	assign in_x    = s_tdata[COORD_W-1:0];
	assign in_y    = s_tdata[2*COORD_W-1:COORD_W];
	assign in_ink  = s_tdata[2*COORD_W];
	assign in_op   = mfb_op_t'(s_tuser);
	assign in_xfer = s_tvalid & s_tready;

	// rotation picks which axis feeds column/row and which are reversed
	always_comb begin
		case (rotation_q)
			2'd0:    begin swap_xy = 1'b0; rev_a = 1'b0; rev_b = 1'b0; end
			2'd1:    begin swap_xy = 1'b1; rev_a = 1'b0; rev_b = 1'b1; end
			2'd2:    begin swap_xy = 1'b0; rev_a = 1'b1; rev_b = 1'b1; end
			default: begin swap_xy = 1'b1; rev_a = 1'b1; rev_b = 1'b0; end
		endcase
	end

	// ---------------- sequencer state ----------------
	mfb_state_t state_q, state_d;

	logic [ADDR_W-1:0]    clr_q;
	logic [ADDR_W-1:0]    ptr_q;
	logic [ADDR_W-1:0]    idx_q;
	logic [PAD_CNT_W-1:0] pad_cnt_q;
	logic                 pad_q;
	logic [1:0]           k_q;
	logic [COORD_W-1:0]   ca_q;     // source coordinate for column
	logic [COORD_W-1:0]   cb_q;     // source coordinate for row
	logic                 fa_q;
	logic                 fb_q;
	logic                 ink_q;
	logic signed [ALU_W-1:0] col_q;
	logic signed [ALU_W-1:0] row_q;

	// output register
	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;
	logic       m_tuser_q;
	logic       m_tlast_q;
	logic       out_free;
	logic       out_load;
	logic [7:0] out_byte;
	logic       out_cmd;
	logic       out_last;

	// shared adder
	mfb_alu_op_t             alu_op;
	logic signed [ALU_W-1:0] alu_a;
	logic signed [ALU_W-1:0] alu_b;
	logic signed [ALU_W-1:0] alu_y;

	// store ports
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [7:0]        mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [7:0]        mem_rdata;

	logic [ALU_W-1:0] prod;
	logic             off_panel;
	logic [7:0]       bit_mask;
	logic             nib_hi;
	logic             nib_lo;

	assign out_free = !m_tvalid_q || m_tready;

	assign prod = ALU_W'(col_q[CW-1:0]) * ALU_W'(STRIDE);
	assign off_panel = col_q[ALU_W-1] || (col_q >= $signed(ALU_W'(PANEL_WIDTH)))
		|| row_q[ALU_W-1] || (row_q >= $signed(ALU_W'(PANEL_HEIGHT)));
	assign bit_mask = 8'h01 << row_q[2:0];

	// k=0 takes bits 7,6 ... k=3 takes bits 1,0
	assign nib_hi = mem_rdata[{~k_q, 1'b1}];
	assign nib_lo = mem_rdata[{~k_q, 1'b0}];

	mfb_alu #(.W(ALU_W)) u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y)
	);

	mfb_store #(.DEPTH(FS_BYTES), .ADDR_W(ADDR_W)) u_store (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (mem_re),
		.raddr   (mem_raddr),
		.rdata_q (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, adder operands, store and output controls
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		alu_op    = ALU_ADD;
		alu_a     = '0;
		alu_b     = '0;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = 8'h00;
		mem_re    = 1'b0;
		mem_raddr = idx_q;
		out_load  = 1'b0;
		out_byte  = PAD_BYTE;
		out_cmd   = 1'b0;
		out_last  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				alu_a     = $signed(ALU_W'(clr_q));
				alu_b     = $signed(ALU_W'(1));
				if (clr_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					case (in_op)
						OP_DRAW:        state_d = ST_MAPC;
						OP_FLUSH_BEGIN: state_d = ST_CMD;
						OP_FLUSH_STEP:  state_d = ST_FRD;
						default:        state_d = ST_IDLE;
					endcase
				end
			end
			ST_MAPC: begin
				if (fa_q) begin
					alu_op = ALU_SUB;
					alu_a  = $signed(ALU_W'(PANEL_WIDTH - 1));
					alu_b  = $signed(ALU_W'(ca_q));
				end else begin
					alu_a  = $signed(ALU_W'(ca_q));
				end
				state_d = ST_MAPR;
			end
			ST_MAPR: begin
				if (fb_q) begin
					alu_op = ALU_SUB;
					alu_a  = $signed(ALU_W'(PANEL_HEIGHT - 1));
					alu_b  = $signed(ALU_W'(cb_q));
				end else begin
					alu_a  = $signed(ALU_W'(cb_q));
				end
				state_d = ST_ADDR;
			end
			ST_ADDR: begin
				alu_a   = $signed(prod);
				alu_b   = row_q >>> 3;
				state_d = off_panel ? ST_IDLE : ST_RD;
			end
			ST_RD: begin
				mem_re  = 1'b1;
				state_d = ST_WR;
			end
			ST_WR: begin
				mem_we    = 1'b1;
				mem_wdata = ink_q ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask);
				state_d   = ST_IDLE;
			end
			ST_CMD: begin
				out_byte = FLUSH_CMDS[k_q];
				out_cmd  = 1'b1;
				out_last = (k_q == 2'd3);
				if (out_free) begin
					out_load = 1'b1;
					if (k_q == 2'd3) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_FRD: begin
				mem_re    = 1'b1;
				mem_raddr = ptr_q;
				alu_op    = ALU_SUB;
				alu_a     = $signed(ALU_W'(ptr_q));
				alu_b     = $signed(ALU_W'(1));
				state_d   = ST_DATA;
			end
			ST_DATA: begin
				out_byte = {{4{nib_hi}}, {4{nib_lo}}};
				out_last = (k_q == 2'd3) && !pad_q;
				if (out_free) begin
					out_load = 1'b1;
					if (k_q == 2'd3) begin
						state_d = pad_q ? ST_PAD : ST_IDLE;
					end
				end
			end
			ST_PAD: begin
				out_byte = PAD_BYTE;
				out_last = 1'b1;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			ptr_q      <= LAST_IDX;
			pad_cnt_q  <= '0;
			pad_q      <= 1'b0;
			k_q        <= 2'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= alu_y[ADDR_W-1:0];
			end
			if (in_xfer) begin
				k_q <= 2'd0;
				if (in_op == OP_FLUSH_BEGIN) begin
					ptr_q     <= LAST_IDX;
					pad_cnt_q <= '0;
				end
			end
			if (state_q == ST_FRD) begin
				ptr_q <= (ptr_q == '0) ? LAST_IDX : alu_y[ADDR_W-1:0];
				if (pad_cnt_q == PAD_CNT_W'(PAD_EVERY - 1)) begin
					pad_cnt_q <= '0;
					pad_q     <= 1'b1;
				end else begin
					pad_cnt_q <= pad_cnt_q + PAD_CNT_W'(1);
					pad_q     <= 1'b0;
				end
			end
			if (out_load) begin
				k_q        <= k_q + 2'd1;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer && in_op == OP_DRAW) begin
			ca_q  <= swap_xy ? in_y : in_x;
			cb_q  <= swap_xy ? in_x : in_y;
			fa_q  <= rev_a ^ mirror_x_q;
			fb_q  <= rev_b ^ mirror_y_q;
			ink_q <= in_ink;
		end
		if (state_q == ST_MAPC) begin
			col_q <= alu_y;
		end
		if (state_q == ST_MAPR) begin
			row_q <= alu_y;
		end
		if (state_q == ST_ADDR) begin
			idx_q <= alu_y[ADDR_W-1:0];
		end
		if (out_load) begin
			m_tdata_q <= out_byte;
			m_tuser_q <= out_cmd;
			m_tlast_q <= out_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// ---------------- assertions ----------------
	a_no_out_during_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !m_tvalid_q)
		else $error("output valid during clearing pass");

	a_ptr_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= LAST_IDX)
		else $error("read pointer beyond frame store");

	a_write_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> mem_waddr <= LAST_IDX)
		else $error("store write beyond frame store");

	a_pad_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		pad_cnt_q < PAD_CNT_W'(PAD_EVERY))
		else $error("pad counter out of range");

	a_draw_in_panel: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD |-> $past(state_q) == ST_ADDR && !$past(off_panel))
		else $error("store update for an off-panel point");

endmodule

@@ tb/framebuffer_checker.sv @@
`timescale 1ns / 1ps
// Checker for the monochrome frame store: watches the pixel stream, the panel byte
// stream and APB writes, predicts every panel byte and compares them in order.
// Depends on mfb_pkg.

module framebuffer_checker #(
	parameter int PANEL_WIDTH  = mfb_pkg::DEF_PANEL_WIDTH,
	parameter int PANEL_HEIGHT = mfb_pkg::DEF_PANEL_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic        m_tuser,
	input  logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          byte_errors,
	output int          bytes_due
);
	import mfb_pkg::*;

	localparam int STRIDE      = (PANEL_HEIGHT + 7) / 8;
	localparam int STORE_BYTES = PANEL_WIDTH * STRIDE;
	localparam int REPORT_MAX  = 10;

	localparam logic [1:0] ROT_0   = 2'd0;
	localparam logic [1:0] ROT_90  = 2'd1;
	localparam logic [1:0] ROT_180 = 2'd2;

	typedef struct packed {
		logic [7:0] value;
		logic       is_cmd;
		logic       last;
	} panel_byte_t;

	typedef struct packed {
		logic               ink;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} draw_req_t;

	logic [7:0]  pixels [STORE_BYTES];
	int          read_idx;
	int          since_pad;
	logic [1:0]  rotation;
	logic        mirror_x;
	logic        mirror_y;
	panel_byte_t due_q[$];
	int          errors;

	task automatic plot_pixel(input draw_req_t req);
		int   a, b, col, row;
		logic rev_col, rev_row;
		case (rotation)
			ROT_0: begin
				a = req.x; b = req.y; rev_col = 1'b0; rev_row = 1'b0;
			end
			ROT_90: begin
				a = req.y; b = req.x; rev_col = 1'b0; rev_row = 1'b1;
			end
			ROT_180: begin
				a = req.x; b = req.y; rev_col = 1'b1; rev_row = 1'b1;
			end
			default: begin
				// 270 degrees
				a = req.y; b = req.x; rev_col = 1'b1; rev_row = 1'b0;
			end
		endcase
		rev_col = rev_col ^ mirror_x;
		rev_row = rev_row ^ mirror_y;
		col = rev_col ? PANEL_WIDTH - 1 - a : a;
		row = rev_row ? PANEL_HEIGHT - 1 - b : b;
		// off-panel points are dropped
		if (col >= 0 && col < PANEL_WIDTH && row >= 0 && row < PANEL_HEIGHT)
			pixels[col * STRIDE + row / 8][row % 8] = req.ink;
	endtask

	task automatic queue_flush_cmds();
		panel_byte_t pb;
		for (int k = 0; k < 4; k++) begin
			pb.value  = FLUSH_CMDS[k];
			pb.is_cmd = 1'b1;
			pb.last   = (k == 3);
			due_q.push_back(pb);
		end
		read_idx  = STORE_BYTES - 1;
		since_pad = 0;
	endtask

	task automatic queue_flush_step();
		logic [7:0]  stored;
		logic        pad;
		panel_byte_t pb;
		stored    = pixels[read_idx];
		read_idx  = (read_idx == 0) ? STORE_BYTES - 1 : read_idx - 1;
		since_pad = since_pad + 1;
		pad       = (since_pad >= PAD_EVERY);
		if (pad)
			since_pad = 0;
		// MSB first, each bit widened to a nibble
		for (int k = 0; k < 4; k++) begin
			pb.value  = {{4{stored[7 - 2 * k]}}, {4{stored[6 - 2 * k]}}};
			pb.is_cmd = 1'b0;
			pb.last   = !pad && (k == 3);
			due_q.push_back(pb);
		end
		if (pad) begin
			pb.value  = PAD_BYTE;
			pb.is_cmd = 1'b0;
			pb.last   = 1'b1;
			due_q.push_back(pb);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		panel_byte_t want, got;
		if (!arst_n) begin
			foreach (pixels[i])
				pixels[i] = '0;
			read_idx  = STORE_BYTES - 1;
			since_pad = 0;
			rotation  = ROT_0;
			mirror_x  = 1'b0;
			mirror_y  = 1'b0;
			due_q.delete();
			errors    = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					CFG_ROTATION: rotation = pwdata[1:0];
					CFG_MIRROR_X: mirror_x = pwdata[0];
					CFG_MIRROR_Y: mirror_y = pwdata[0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					OP_DRAW:        plot_pixel(draw_req_t'(s_tdata[20:0]));
					OP_FLUSH_BEGIN: queue_flush_cmds();
					OP_FLUSH_STEP:  queue_flush_step();
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.value  = m_tdata;
				got.is_cmd = m_tuser;
				got.last   = m_tlast;
				if (due_q.size() == 0) begin
					errors = errors + 1;
					if (errors <= REPORT_MAX)
						$display("%0t: unexpected byte %02h cmd %0b last %0b", $realtime,
							got.value, got.is_cmd, got.last);
				end else begin
					want = due_q.pop_front();
					if (got.value !== want.value || got.is_cmd !== want.is_cmd ||
							got.last !== want.last) begin
						errors = errors + 1;
						if (errors <= REPORT_MAX)
							$display("%0t: expected byte %02h cmd %0b last %0b, got %02h %0b %0b",
								$realtime, want.value, want.is_cmd, want.last,
								got.value, got.is_cmd, got.last);
					end
				end
			end
		end
		byte_errors <= errors;
		bytes_due   <= due_q.size();
	end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Top of the frame store testbench: clock, reset, pixel stream and APB stimulus,
// random backpressure, watchdog and verdict.
// Depends on mfb_pkg, mono_framebuffer_rotate_flush_core and framebuffer_checker.

module testbench;
	import mfb_pkg::*;

	localparam int CLK_HALF      = 2;
	localparam int MAX_GAP       = 17;
	// a draw leaves no byte behind, so wait well past the end of a trailing draw
	localparam int DRAIN_CYCLES  = 16;
	// the clearing sweep after reset keeps s_tready low while it writes all 3200 bytes
	localparam int QUIET_LIMIT   = 20000;
	localparam int PHASE_ITEMS   = 40;
	localparam int RANDOM_PHASES = 6;
	localparam int EDGE_HI       = DEF_PANEL_WIDTH - 1;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [1:0] ROT_0     = 2'd0;
	localparam logic [1:0] ROT_90    = 2'd1;
	localparam logic [1:0] ROT_180   = 2'd2;
	localparam logic [1:0] ROT_270   = 2'd3;

	localparam logic [COORD_W-1:0] COORD_MAX = '1;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;   // pos_x[9:0], pos_y[19:10], ink_white[20], zero[23:21]
	logic [1:0]  s_tuser  = '0;   // opcode[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;         // out_byte[7:0]
	logic        m_tuser;         // is_command[0]
	logic        m_tlast;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [3:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	int byte_errors;
	int bytes_due;
	int quiet_cycles = 0;
	bit send_burst   = 1'b0;   // sender runs back to back while set
	bit sink_burst   = 1'b0;   // receiver never stalls while set

	mono_framebuffer_rotate_flush_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	framebuffer_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.byte_errors (byte_errors),
		.bytes_due   (bytes_due)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Watchdog: any transfer on either stream or an APB access counts as progress.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL mono_framebuffer_rotate_flush_core");
			$finish;
		end
	end

	// Panel side: a fresh random stall before every byte, with
	// occasional runs of no stall at all.
	initial begin : panel_sink
		int stall;
		wait (arst_n);
		forever begin
			stall = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if ($urandom_range(0, 63) == 0)
				sink_burst = !sink_burst;
		end
	end

	// One input transfer. The gap is drawn per item; a zero gap keeps s_tvalid
	// high so consecutive items go out back to back.
	task automatic send_item(input logic [1:0] op, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic ink);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
		if ($urandom_range(0, 39) == 0)
			send_burst = !send_burst;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {3'b000, ink, y, x};
		do @(posedge clk); while (!s_tready);
	endtask

	// Flush items ignore the coordinate fields; fill them with noise anyway.
	task automatic send_flush(input logic [1:0] op);
		send_item(op, COORD_W'($urandom()), COORD_W'($urandom()),
			1'($urandom_range(0, 1)));
	endtask

	// APB write: setup cycle, access cycle, then psel is driven low before the task
	// returns, so back-to-back writes never assign psel twice in one step.
	task automatic reg_write(input logic [1:0] index, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Upper bits carry noise: the block must mask to the field width.
	task automatic set_config(input logic [1:0] rot, input logic mx, input logic my);
		reg_write(CFG_ROTATION, ($urandom() & 32'hFFFF_FFFC) | 32'(rot));
		reg_write(CFG_MIRROR_X, ($urandom() & 32'hFFFF_FFFE) | 32'(mx));
		reg_write(CFG_MIRROR_Y, ($urandom() & 32'hFFFF_FFFE) | 32'(my));
	endtask

	// Drop valid and wait until every predicted byte has been seen, then give
	// a trailing draw time to finish before the registers change.
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (bytes_due != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Coordinates lean toward the panel borders: after any rotation or mirror
	// these land in the first and last columns, which the reader visits last and first.
	function automatic logic [COORD_W-1:0] pick_coord();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return COORD_W'($urandom_range(0, 7));
		if (r < 75)
			return COORD_W'($urandom_range(EDGE_HI - 7, EDGE_HI));
		if (r < 92)
			return COORD_W'($urandom_range(0, EDGE_HI));
		return COORD_W'($urandom_range(0, COORD_MAX));
	endfunction

	// Mostly draws and flush runs (begin followed by steps, some long enough to
	// cross the pad point), plus stray steps and the unused opcode as noise.
	task automatic random_phase(input int items);
		int sent, steps, r;
		sent = 0;
		while (sent < items) begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				send_item(OP_DRAW, pick_coord(), pick_coord(), $urandom_range(0, 9) < 7);
				sent++;
			end else if (r < 53) begin
				send_flush(OP_UNUSED);
			end else if (r < 58) begin
				send_flush(OP_FLUSH_STEP);
				sent++;
			end else begin
				if (r < 95) begin
					send_flush(OP_FLUSH_BEGIN);
					sent++;
				end
				steps = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 45)
					: $urandom_range(1, 12);
				repeat (steps) begin
					send_flush(OP_FLUSH_STEP);
					sent++;
				end
			end
		end
	endtask

	initial begin : stimulus
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// registers are taken while the store is still being cleared
		set_config(ROT_0, 1'b0, 1'b0);

		// Directed: a step before any flush begin reads the last byte and
		// advances the pad count; then pixels set and cleared in that byte.
		send_flush(OP_FLUSH_STEP);
		send_item(OP_DRAW, COORD_W'(EDGE_HI), COORD_W'(EDGE_HI), 1'b1);
		send_item(OP_DRAW, COORD_W'(EDGE_HI), COORD_W'(EDGE_HI - 7), 1'b1);
		send_item(OP_DRAW, COORD_W'(EDGE_HI), COORD_W'(EDGE_HI - 3), 1'b1);
		send_item(OP_DRAW, COORD_W'(EDGE_HI), COORD_W'(EDGE_HI - 3), 1'b0);
		// off panel: all-ones coordinates and each axis exactly at the edge; then the origin
		send_item(OP_DRAW, COORD_MAX, COORD_MAX, 1'b1);
		send_item(OP_DRAW, COORD_W'(DEF_PANEL_WIDTH), '0, 1'b1);
		send_item(OP_DRAW, '0, COORD_W'(DEF_PANEL_HEIGHT), 1'b1);
		send_item(OP_DRAW, '0, '0, 1'b1);
		// unused opcode with every coordinate and ink bit high must change nothing
		send_item(OP_UNUSED, COORD_MAX, COORD_MAX, 1'b1);
		send_flush(OP_FLUSH_BEGIN);
		send_flush(OP_FLUSH_STEP);
		send_flush(OP_FLUSH_STEP);
		send_flush(OP_FLUSH_STEP);
		settle();

		// Random phases, each under its own orientation; the extremes come first.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: set_config(ROT_270, 1'b1, 1'b1);
				1: set_config(ROT_90, 1'b0, 1'b1);
				2: set_config(ROT_180, 1'b1, 1'b0);
				3: set_config(ROT_0, 1'b1, 1'b0);
				default: set_config(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			endcase
			random_phase(PHASE_ITEMS);
			settle();
		end

		// Closing run: a flush begin and enough steps to cross the pad point.
		send_flush(OP_FLUSH_BEGIN);
		repeat (PAD_EVERY + 4)
			send_flush(OP_FLUSH_STEP);
		settle();

		if (byte_errors == 0)
			$display("PASS mono_framebuffer_rotate_flush_core");
		else
			$display("FAIL mono_framebuffer_rotate_flush_core");
		$finish;
	end

endmodule
